### sv/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types, codes and helpers of the timed task dispatch queue
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int TableDepthDef  = 32;
  localparam int CancelDepthDef = 16;
  localparam int MaxResults     = 32;

  localparam int TimeW  = 48;
  localparam int OrderW = 32;
  localparam int IdentW = 32;
  localparam int TagW   = 16;
  localparam int DurW   = 16;
  localparam int CmdW   = 3;
  localparam int KindW  = 2;
  localparam int CountW = $clog2(MaxResults + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_SEND     = 3'd0,
    CMD_SEND_EXP = 3'd1,
    CMD_SCHED    = 3'd2,
    CMD_CANCEL   = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_IDENT       = 2'd0,
    KIND_RELEASE     = 2'd1,
    KIND_TABLE_FULL  = 2'd2,
    KIND_CANCEL_FULL = 2'd3
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic [TimeW-1:0]  fire;
    logic [OrderW-1:0] order;
    logic [TimeW-1:0]  deadline;
    logic              has_dl;
    logic [IdentW-1:0] ident;
    logic [TagW-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } chain_ctl_t;

  function automatic logic key_lt(entry_t a, entry_t b);
    return (a.fire < b.fire) || ((a.fire == b.fire) && (a.order < b.order));
  endfunction

endpackage

### sv/tdq_cell.sv
// ----------------------------------------------------------------------------
// tdq_cell
// one slot of the sorted task chain: insert shifts right, pop shifts left
// ----------------------------------------------------------------------------
module tdq_cell import tdq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_gt_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       gt_o
);

  logic   valid_q, valid_d;
  entry_t data_q, data_d;

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

  assign gt_o = !valid_q || key_lt(new_i, entry_o);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.pop) begin
      valid_d = right_i.valid;
      data_d  = right_i;
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        valid_d = left_i.valid;
        data_d  = left_i;
      end else if (gt_o) begin
        valid_d = 1'b1;
        data_d  = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### sv/timed_task_dispatch_queue.sv
// ----------------------------------------------------------------------------
// timed_task_dispatch_queue
// timer queue kept as a sorted chain of cells, with a cancel list
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  command  | start / busy            | command, duration_ms, task_tag,
//           |                         | cancel_ident
//  result   | strobe_o, one cycle     | kind, released_tag, task_ident, last
//
//  non-tick item: accepted when idle, then the exec state updates the cell chain
//  tick: accepted when idle, then the tick state takes due tasks one at a time
//  from the head of the chain (at most the release limit of released tasks per tick)
//  reset empties the chain and the cancel list at once, no clearing pass
//  results cannot be stalled; each is shown for one cycle only
// ----------------------------------------------------------------------------
module timed_task_dispatch_queue import tdq_pkg::*; #(
  parameter int TABLE_DEPTH  = TableDepthDef,
  parameter int CANCEL_DEPTH = CancelDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CmdW-1:0]   command_i,
  input  logic [DurW-1:0]   duration_ms_i,
  input  logic [TagW-1:0]   task_tag_i,
  input  logic [IdentW-1:0] cancel_ident_i,
  output logic              strobe_o,
  output logic [KindW-1:0]  kind_o,
  output logic [TagW-1:0]   released_tag_o,
  output logic [IdentW-1:0] task_ident_o,
  output logic              last_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_TICK} state_e;

  state_e            state_q;
  logic [CmdW-1:0]   cmd_q;
  logic [DurW-1:0]   dur_q;
  logic [TagW-1:0]   tag_q;
  logic [IdentW-1:0] cid_q;
  logic [TimeW-1:0]  now_q;
  logic [IdentW-1:0] ident_q;
  logic [OrderW-1:0] order_q;
  logic [CountW-1:0] n_q;
  logic              pend_v_q;
  logic [TagW-1:0]   pend_tag_q;
  logic [IdentW-1:0] pend_ident_q;

  entry_t     cells [TABLE_DEPTH];
  logic       gt    [TABLE_DEPTH];
  entry_t     new_entry;
  entry_t     head;
  chain_ctl_t ctl;
  logic [IdentW-1:0] ident_next;
  logic       full, is_task, is_sched;

  logic [IdentW-1:0]       cancel_id_q [CANCEL_DEPTH];
  logic [CANCEL_DEPTH-1:0] cancel_v_q, cancel_free, cancel_first_free;
  logic [CANCEL_DEPTH-1:0] cancel_match, cancel_first_match;
  logic cancel_full, cancel_wr, cancel_hit, cancel_clr;
  logic due, can_pop, expired, release_now, tick_end;

  assign busy     = (state_q != ST_IDLE);
  assign head     = cells[0];
  assign full     = cells[TABLE_DEPTH-1].valid;
  assign is_task  = (cmd_q == CMD_SEND) || (cmd_q == CMD_SEND_EXP) || (cmd_q == CMD_SCHED);
  assign is_sched = (cmd_q == CMD_SCHED);

  assign ident_next = (ident_q + 1'b1 == '0) ? IdentW'(1) : ident_q + 1'b1;

  always_comb begin
    new_entry.valid    = 1'b1;
    new_entry.fire     = is_sched ? now_q + TimeW'(dur_q) : now_q;
    new_entry.order    = order_q + 1'b1;
    new_entry.deadline = now_q + TimeW'(dur_q);
    new_entry.has_dl   = (cmd_q == CMD_SEND_EXP);
    new_entry.ident    = is_sched ? ident_next : '0;
    new_entry.tag      = tag_q;
  end

  // tick release path
  always_comb begin
    for (int j = 0; j < CANCEL_DEPTH; j++) begin
      cancel_match[j] = cancel_v_q[j] && (cancel_id_q[j] == head.ident);
    end
  end
  assign cancel_first_match = cancel_match & (~cancel_match + 1'b1);
  assign cancel_hit  = (head.ident != '0) && (|cancel_match);
  assign due         = head.valid && (head.fire <= now_q);
  assign can_pop     = (n_q < CountW'(MaxResults));
  assign expired     = head.has_dl && (head.deadline <= now_q);
  assign ctl.pop     = (state_q == ST_TICK) && due && can_pop;
  assign ctl.ins     = (state_q == ST_EXEC) && is_task && !full;
  assign release_now = ctl.pop && !cancel_hit && !expired;
  assign tick_end    = (state_q == ST_TICK) && !(due && can_pop);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tdq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .new_i     (new_entry),
      .left_i    ((i == 0) ? entry_t'('0) : cells[(i == 0) ? 0 : i-1]),
      .left_gt_i ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .right_i   ((i == TABLE_DEPTH-1) ? entry_t'('0)
                                       : cells[(i == TABLE_DEPTH-1) ? i : i+1]),
      .entry_o   (cells[i]),
      .gt_o      (gt[i])
    );
  end

  // cancel list
  assign cancel_free       = ~cancel_v_q;
  assign cancel_first_free = cancel_free & (~cancel_free + 1'b1);
  assign cancel_full       = &cancel_v_q;
  assign cancel_wr  = (state_q == ST_EXEC) && (cmd_q == CMD_CANCEL) && (cid_q != '0)
                      && !cancel_full;
  assign cancel_clr = tick_end && !head.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cancel_v_q <= '0;
    end else if (cancel_clr) begin
      cancel_v_q <= '0;
    end else if (cancel_wr) begin
      cancel_v_q <= cancel_v_q | cancel_first_free;
    end else if (ctl.pop && cancel_hit) begin
      cancel_v_q <= cancel_v_q & ~cancel_first_match;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < CANCEL_DEPTH; j++) begin
      if (cancel_wr && cancel_first_free[j]) begin
        cancel_id_q[j] <= cid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= '0;
      dur_q          <= '0;
      tag_q          <= '0;
      cid_q          <= '0;
      now_q          <= '0;
      ident_q        <= '0;
      order_q        <= '0;
      n_q            <= '0;
      pend_v_q       <= 1'b0;
      pend_tag_q     <= '0;
      pend_ident_q   <= '0;
      strobe_o       <= 1'b0;
      kind_o         <= '0;
      released_tag_o <= '0;
      task_ident_o   <= '0;
      last_o         <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= command_i;
            dur_q <= duration_ms_i;
            tag_q <= task_tag_i;
            cid_q <= cancel_ident_i;
            if (command_i == CMD_TICK) begin
              now_q    <= now_q + 1'b1;
              n_q      <= '0;
              pend_v_q <= 1'b0;
              state_q  <= ST_TICK;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (is_task) begin
            if (full) begin
              strobe_o       <= 1'b1;
              kind_o         <= KIND_TABLE_FULL;
              released_tag_o <= tag_q;
              task_ident_o   <= '0;
              last_o         <= 1'b1;
            end else begin
              order_q <= order_q + 1'b1;
              if (is_sched) begin
                ident_q        <= ident_next;
                strobe_o       <= 1'b1;
                kind_o         <= KIND_IDENT;
                released_tag_o <= tag_q;
                task_ident_o   <= ident_next;
                last_o         <= 1'b1;
              end
            end
          end else if ((cmd_q == CMD_CANCEL) && (cid_q != '0) && cancel_full) begin
            strobe_o       <= 1'b1;
            kind_o         <= KIND_CANCEL_FULL;
            released_tag_o <= '0;
            task_ident_o   <= cid_q;
            last_o         <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        ST_TICK: begin
          if (release_now) begin
            if (pend_v_q) begin
              strobe_o       <= 1'b1;
              kind_o         <= KIND_RELEASE;
              released_tag_o <= pend_tag_q;
              task_ident_o   <= pend_ident_q;
              last_o         <= 1'b0;
            end
            pend_v_q     <= 1'b1;
            pend_tag_q   <= head.tag;
            pend_ident_q <= head.ident;
            n_q          <= n_q + 1'b1;
          end else if (tick_end) begin
            if (pend_v_q) begin
              strobe_o       <= 1'b1;
              kind_o         <= KIND_RELEASE;
              released_tag_o <= pend_tag_q;
              task_ident_o   <= pend_ident_q;
              last_o         <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### sv/tdq_checker.sv
// ----------------------------------------------------------------------------
// tdq_checker
// port-level checks of the timed task dispatch queue
// ----------------------------------------------------------------------------
module tdq_checker import tdq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              strobe_o,
  input logic [KindW-1:0]  kind_o,
  input logic [TagW-1:0]   released_tag_o,
  input logic [IdentW-1:0] task_ident_o,
  input logic              last_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (last_o == !busy)) else $error("last item out of step with busy");

  a_ident_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == KIND_IDENT) |-> last_o && (task_ident_o != '0))
    else $error("bad identifier item");

  a_table_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == KIND_TABLE_FULL) |-> last_o && (task_ident_o == '0))
    else $error("bad table full item");

  a_cancel_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == KIND_CANCEL_FULL) |->
      last_o && (released_tag_o == '0) && (task_ident_o != '0))
    else $error("bad cancel full item");

endmodule

bind timed_task_dispatch_queue tdq_checker u_tdq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .strobe_o       (strobe_o),
  .kind_o         (kind_o),
  .released_tag_o (released_tag_o),
  .task_ident_o   (task_ident_o),
  .last_o         (last_o)
);
